// ----- rtl/executable_format_sniffer_assert.svh -----
// Assertion macros for the executable format sniffer.
// Used by the top level; needs no other file.
`ifndef EXECUTABLE_FORMAT_SNIFFER_ASSERT_SVH
`define EXECUTABLE_FORMAT_SNIFFER_ASSERT_SVH
`ifndef SYNTH
// A property checked at every rising edge outside reset.
`define EFS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// A condition that must hold in the cycle after a trigger.
`define EFS_ASSERT_NEXT(lbl, clk, rstn, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) trig |=> cond) else $error(msg);
`else
`define EFS_ASSERT(lbl, clk, rstn, prop, msg)
`define EFS_ASSERT_NEXT(lbl, clk, rstn, trig, cond, msg)
`endif
`endif

// ----- rtl/efs_pkg.sv -----
// Shared types, constants and the PE signature step for the format sniffer.
// No dependencies.
package efs_pkg;

    // Header store geometry.
    localparam int HDR_BYTES = 64;
    localparam int HDR_AW    = $clog2(HDR_BYTES);

    // Default width of the byte position counter.
    localparam int POS_BITS_DEFAULT = 32;

    // Fixed positions in the file header.
    localparam int POS_ELF_CLASS = 4;
    localparam int POS_OFF_LO    = 'h3C;
    localparam int POS_HDR_LAST  = HDR_BYTES - 1;

    // Magic numbers, packed little-endian as they arrive.
    localparam logic [31:0] ELF_MAGIC  = 32'h464C_457F;
    localparam logic [15:0] MZ_MAGIC   = 16'h5A4D;
    localparam logic [7:0]  ELF_CLS32  = 8'h01;
    localparam logic [7:0]  ELF_CLS64  = 8'h02;
    localparam logic [15:0] MACH_X86   = 16'h014C;
    localparam logic [15:0] MACH_X64   = 16'h8664;
    localparam logic [7:0]  PE_SIG [4] = '{8'h50, 8'h45, 8'h00, 8'h00};

    // Progress through the PE signature and machine word.
    localparam logic [2:0] PROG_MLOW  = 3'd4;
    localparam logic [2:0] PROG_MHIGH = 3'd5;
    localparam logic [2:0] PROG_DONE  = 3'd6;
    localparam logic [2:0] PROG_OFF   = 3'd7;

    typedef enum logic [2:0] {
        CLS_UNKNOWN = 3'd0,
        CLS_PE_X86  = 3'd1,
        CLS_PE_X64  = 3'd2,
        CLS_ELF_32  = 3'd3,
        CLS_ELF_64  = 3'd4
    } t_class;

    typedef struct packed {
        logic [2:0] prog;
        logic [7:0] mlow;
        t_class     verdict;
    } t_pe;

    // Write and read-back requests to the header store.
    typedef struct packed {
        logic              wr_en;
        logic [HDR_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              start;
        logic [HDR_AW-1:0] base;
    } t_walk_req;

    // Bytes returned by the read-back, in offset order.
    typedef struct packed {
        logic       busy;
        logic       take;
        logic [7:0] data;
    } t_walk_rsp;

    // Feed one PE signature or machine byte; done or failed progress ignores it.
    function automatic t_pe pe_take(t_pe s, logic [7:0] v);
        t_pe         r;
        logic [15:0] mach;
        r    = s;
        mach = {v, s.mlow};
        if (s.prog < PROG_MLOW) begin
            r.prog = (v == PE_SIG[s.prog[1:0]]) ? s.prog + 3'd1 : PROG_OFF;
        end else if (s.prog == PROG_MLOW) begin
            r.mlow = v;
            r.prog = PROG_MHIGH;
        end else if (s.prog == PROG_MHIGH) begin
            if (mach == MACH_X86) begin
                r.verdict = CLS_PE_X86;
            end else if (mach == MACH_X64) begin
                r.verdict = CLS_PE_X64;
            end
            r.prog = PROG_DONE;
        end
        return r;
    endfunction

endpackage

// ----- rtl/efs_hdr_walk.sv -----
// Header store memory and the read-back of PE bytes that lie inside the header.
// Depends on efs_pkg.
module efs_hdr_walk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  efs_pkg::t_walk_req i_req,
    output efs_pkg::t_walk_rsp o_rsp
);

    localparam int AW = efs_pkg::HDR_AW;

    logic [7:0]  r_mem [efs_pkg::HDR_BYTES];
    logic        r_active;
    logic        r_rd_valid;
    logic [2:0]  r_idx;
    logic [AW-1:0] r_base;
    logic [7:0]  r_rd_data;
    logic [AW:0] rd_sum;
    logic        can_issue;

    // Next offset to read; stop after six bytes or at the end of the header.
    assign rd_sum    = {1'b0, r_base} + (AW+1)'(r_idx);
    assign can_issue = r_active && (r_idx != efs_pkg::PROG_DONE) && !rd_sum[AW];

    // Header bytes are written as they stream in.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (can_issue) begin
            r_rd_data <= r_mem[rd_sum[AW-1:0]];
        end
    end

    // Start offset of the read-back.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_base <= i_req.base;
        end
    end

    // Read-back sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_rd_valid <= 1'b0;
            r_idx      <= 3'd0;
        end else begin
            r_rd_valid <= can_issue;
            if (i_req.start) begin
                r_active <= 1'b1;
                r_idx    <= 3'd0;
            end else if (can_issue) begin
                r_idx <= r_idx + 3'd1;
            end else begin
                r_active <= 1'b0;
            end
        end
    end

    assign o_rsp.busy = r_active | r_rd_valid;
    assign o_rsp.take = r_rd_valid;
    assign o_rsp.data = r_rd_data;

endmodule

// ----- rtl/executable_format_sniffer.sv -----
// The class leaves in the cycle after the last byte is accepted, or, when the file ends on
// byte 63 of an MZ file whose PE header offset lies inside the header, after the read-back.
// Throughput: one byte per cycle when not stalled; after byte 63 of such a file
// the input is held while the single read port of the header store returns the PE bytes.
// Reset is synchronous and active low; it clears control state, not the header store.
module executable_format_sniffer #(
    parameter int POSITION_BITS = efs_pkg::POS_BITS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_file_class
);

`include "executable_format_sniffer_assert.svh"

    localparam int PB = POSITION_BITS;
    localparam int AW = efs_pkg::HDR_AW;

    logic [PB-1:0]      r_pos;
    logic [PB-1:0]      n_pos;
    logic [31:0]        r_off;
    logic [31:0]        n_off;
    logic [2:0]         r_prog;
    logic [7:0]         r_mlow;
    efs_pkg::t_class    r_verdict;
    efs_pkg::t_pe       n_pe;
    logic               r_pend_last;
    logic               n_pend_last;
    logic [31:0]        r_magic;
    logic [23:0]        r_offb;
    logic               r_out_valid;
    efs_pkg::t_class    r_out_class;

    efs_pkg::t_walk_req w_req;
    efs_pkg::t_walk_rsp w_rsp;

    logic               in_acc;
    logic               out_free;
    logic               pos_lt4;
    logic               pos_is_elf;
    logic               pos_lt64;
    logic               pos_is_last;
    logic               pos_off_bytes;
    logic               pos_max;
    logic [31:0]        full_off;
    logic [PB:0]        target;
    logic               start;
    logic               emit;
    logic               clear;
    efs_pkg::t_class    emit_class;

    // Handshake.
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = w_rsp.busy | r_pend_last | (i_last_byte & ~out_free);
    assign in_acc     = i_in_valid & ~o_in_stall;

    // Position decodes.
    assign pos_lt4       = (r_pos < PB'(4));
    assign pos_is_elf    = (r_pos == PB'(efs_pkg::POS_ELF_CLASS));
    assign pos_lt64      = (r_pos[PB-1:AW] == '0);
    assign pos_is_last   = (r_pos == PB'(efs_pkg::POS_HDR_LAST));
    assign pos_off_bytes = (r_pos >= PB'(efs_pkg::POS_OFF_LO)) &&
                           (r_pos < PB'(efs_pkg::POS_HDR_LAST));
    assign pos_max       = &r_pos;
    assign full_off      = {i_data_byte, r_offb};
    assign target        = (PB+1)'(r_off) + (PB+1)'(r_prog);

    // Header store writes and the in-header read-back request.
    assign w_req.wr_en   = in_acc & pos_lt64;
    assign w_req.wr_addr = r_pos[AW-1:0];
    assign w_req.wr_data = i_data_byte;
    assign w_req.start   = start;
    assign w_req.base    = full_off[AW-1:0];

    efs_hdr_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Next state for one beat, a read-back byte, or a deferred result.
    always_comb begin
        n_pos       = r_pos;
        n_off       = r_off;
        n_pe        = '{prog: r_prog, mlow: r_mlow, verdict: r_verdict};
        n_pend_last = r_pend_last;
        start       = 1'b0;
        emit        = 1'b0;
        clear       = 1'b0;
        emit_class  = r_verdict;

        if (w_rsp.take) begin
            n_pe = efs_pkg::pe_take(n_pe, w_rsp.data);
        end

        if (in_acc) begin
            // ELF class byte.
            if (pos_is_elf && (r_magic == efs_pkg::ELF_MAGIC)) begin
                if (i_data_byte == efs_pkg::ELF_CLS32) begin
                    n_pe.verdict = efs_pkg::CLS_ELF_32;
                end else if (i_data_byte == efs_pkg::ELF_CLS64) begin
                    n_pe.verdict = efs_pkg::CLS_ELF_64;
                end
            end

            // End of header: latch the PE offset and read back any bytes inside it.
            if (pos_is_last) begin
                n_off = full_off;
                if (r_magic[15:0] == efs_pkg::MZ_MAGIC) begin
                    n_pe.prog = 3'd0;
                    if (full_off[31:AW] == '0) begin
                        start = 1'b1;
                    end
                end else begin
                    n_pe.prog = efs_pkg::PROG_OFF;
                end
            end else if (!pos_lt64 && (r_prog < efs_pkg::PROG_DONE) &&
                         (target == {1'b0, r_pos})) begin
                n_pe = efs_pkg::pe_take(n_pe, i_data_byte);
            end

            if (!pos_max) begin
                n_pos = r_pos + PB'(1);
            end

            if (i_last_byte) begin
                if (start) begin
                    n_pend_last = 1'b1;
                end else begin
                    emit       = 1'b1;
                    emit_class = n_pe.verdict;
                    clear      = 1'b1;
                end
            end
        end

        // Result held back until the read-back has finished.
        if (r_pend_last && !w_rsp.busy && out_free) begin
            emit        = 1'b1;
            emit_class  = r_verdict;
            clear       = 1'b1;
            n_pend_last = 1'b0;
        end

        if (clear) begin
            n_pos        = '0;
            n_off        = '0;
            n_pe.prog    = 3'd0;
            n_pe.mlow    = 8'd0;
            n_pe.verdict = efs_pkg::CLS_UNKNOWN;
        end
    end

    // Control and classification state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_off       <= '0;
            r_prog      <= 3'd0;
            r_mlow      <= 8'd0;
            r_verdict   <= efs_pkg::CLS_UNKNOWN;
            r_pend_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_off       <= n_off;
            r_prog      <= n_pe.prog;
            r_mlow      <= n_pe.mlow;
            r_verdict   <= n_pe.verdict;
            r_pend_last <= n_pend_last;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Magic bytes and the PE offset bytes are caught as they stream past.
    always_ff @(posedge i_clk) begin
        if (in_acc && pos_lt4) begin
            r_magic <= {i_data_byte, r_magic[31:8]};
        end
        if (in_acc && pos_off_bytes) begin
            r_offb <= {i_data_byte, r_offb[23:8]};
        end
        if (emit) begin
            r_out_class <= emit_class;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_file_class = r_out_class;

    `EFS_ASSERT(a_no_beat_during_walk, i_clk, i_rst_n, w_rsp.take |-> !in_acc, "beat taken during read-back")
    `EFS_ASSERT(a_walk_follows_beat, i_clk, i_rst_n, $rose(w_rsp.busy) |-> $past(in_acc), "read-back without a header beat")
    `EFS_ASSERT(a_class_legal, i_clk, i_rst_n, o_out_valid |-> (o_file_class <= efs_pkg::CLS_ELF_64), "illegal class code")
    `EFS_ASSERT(a_pe_after_header, i_clk, i_rst_n, (r_verdict == efs_pkg::CLS_PE_X86 || r_verdict == efs_pkg::CLS_PE_X64) |-> !pos_lt64, "PE verdict inside header")
    `EFS_ASSERT_NEXT(a_pending_holds_input, i_clk, i_rst_n, r_pend_last && w_rsp.busy, !in_acc, "beat taken while result deferred")

endmodule

// ----- tb/executable_format_sniffer_test.sv -----
// Self-checking testbench for the executable format sniffer: whole files are streamed
// in byte beats and each class beat is compared with a predictor of the classification.
// Depends on efs_pkg and the executable_format_sniffer top level.
module executable_format_sniffer_test;

    localparam int IDLE_PCT    = 31;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 16;
    localparam int BEAT_GOAL   = 1750;
    localparam int FILE_GOAL   = 40;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_data_byte;
    logic       i_last_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [2:0] o_file_class;

    executable_format_sniffer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_file_class (o_file_class)
    );

    // Shape of a generated file.
    typedef enum {FK_RAW, FK_ELF, FK_MZ} t_file_kind;

    typedef struct {
        t_file_kind      kind;
        int              len;
        int              fill;      // negative means random contents
        logic [7:0]      elf_cls;
        logic [31:0]     pe_off;
        logic [15:0]     mach;
        bit              sig_bad;
        bit              typed;     // the class below is known by inspection
        efs_pkg::t_class want;
    } t_file_case;

    // Directed files: extremes, each class, short files and offsets around the header end.
    t_file_case directed_cases [23] = '{
        '{FK_RAW, 1,   0,   8'h00, 32'h0, 16'h0, 1'b0, 1'b1, efs_pkg::CLS_UNKNOWN},
        '{FK_RAW, 3,   255, 8'h00, 32'h0, 16'h0, 1'b0, 1'b1, efs_pkg::CLS_UNKNOWN},
        '{FK_ELF, 5,   -1, efs_pkg::ELF_CLS32, 32'h0, 16'h0, 1'b0, 1'b1, efs_pkg::CLS_ELF_32},
        '{FK_ELF, 5,   -1, efs_pkg::ELF_CLS64, 32'h0, 16'h0, 1'b0, 1'b1, efs_pkg::CLS_ELF_64},
        '{FK_ELF, 4,   -1, efs_pkg::ELF_CLS32, 32'h0, 16'h0, 1'b0, 1'b1, efs_pkg::CLS_UNKNOWN},
        '{FK_ELF, 9,   0,   8'h00, 32'h0, 16'h0, 1'b0, 1'b1, efs_pkg::CLS_UNKNOWN},
        '{FK_ELF, 9,   255, 8'hFF, 32'h0, 16'h0, 1'b0, 1'b1, efs_pkg::CLS_UNKNOWN},
        '{FK_ELF, 70,  -1, efs_pkg::ELF_CLS32, 32'h0, 16'h0, 1'b0, 1'b1, efs_pkg::CLS_ELF_32},
        '{FK_MZ,  63,  -1, 8'h00, 32'h80, efs_pkg::MACH_X86, 1'b0, 1'b1, efs_pkg::CLS_UNKNOWN},
        '{FK_MZ,  134, -1, 8'h00, 32'h80, efs_pkg::MACH_X86, 1'b0, 1'b1, efs_pkg::CLS_PE_X86},
        '{FK_MZ,  144, -1, 8'h00, 32'h80, efs_pkg::MACH_X64, 1'b0, 1'b1, efs_pkg::CLS_PE_X64},
        '{FK_MZ,  133, -1, 8'h00, 32'h80, efs_pkg::MACH_X64, 1'b0, 1'b1, efs_pkg::CLS_UNKNOWN},
        '{FK_MZ,  140, -1, 8'h00, 32'h80, efs_pkg::MACH_X86, 1'b1, 1'b1, efs_pkg::CLS_UNKNOWN},
        '{FK_MZ,  140, -1, 8'h00, 32'h80, 16'hFFFF,          1'b0, 1'b1, efs_pkg::CLS_UNKNOWN},
        '{FK_MZ,  64,  -1, 8'h00, 32'h10, efs_pkg::MACH_X64, 1'b0, 1'b1, efs_pkg::CLS_PE_X64},
        '{FK_MZ,  100, -1, 8'h00, 32'h28, efs_pkg::MACH_X86, 1'b0, 1'b1, efs_pkg::CLS_PE_X86},
        '{FK_MZ,  40,  -1, 8'h00, 32'h10, efs_pkg::MACH_X86, 1'b0, 1'b1, efs_pkg::CLS_UNKNOWN},
        '{FK_MZ,  70,  -1, 8'h00, 32'h40, efs_pkg::MACH_X86, 1'b0, 1'b1, efs_pkg::CLS_PE_X86},
        '{FK_MZ,  80,  -1, 8'h00, 32'h3A, efs_pkg::MACH_X64, 1'b0, 1'b0, efs_pkg::CLS_UNKNOWN},
        '{FK_MZ,  80,  -1, 8'h00, 32'h3E, efs_pkg::MACH_X86, 1'b0, 1'b0, efs_pkg::CLS_UNKNOWN},
        '{FK_MZ,  80,  -1, 8'h00, 32'h3F, efs_pkg::MACH_X64, 1'b0, 1'b0, efs_pkg::CLS_UNKNOWN},
        '{FK_MZ,  70,  -1, 8'h00, 32'hFFFF_FFFF, efs_pkg::MACH_X86, 1'b0, 1'b1,
          efs_pkg::CLS_UNKNOWN},
        '{FK_MZ,  90,  255, 8'h00, 32'h0, efs_pkg::MACH_X64, 1'b0, 1'b0, efs_pkg::CLS_UNKNOWN}
    };

    // Predictor state for the file in flight.
    logic [31:0]     pos_next;
    logic [7:0]      hdr_copy [efs_pkg::HDR_BYTES];
    logic [31:0]     pe_offset;
    logic [2:0]      pe_progress;
    logic [7:0]      mach_low;
    efs_pkg::t_class verdict_so_far;

    efs_pkg::t_class class_due [$];
    efs_pkg::t_class typed_cls;
    bit              typed_on;
    bit              calm;
    int              hold_left;
    int              beats_sent;
    int              files_done;
    int              mismatches;
    int              quiet_cycles;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [2:0] got,
                                   input logic [2:0] want);
        $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic clear_tracker();
        pos_next       = '0;
        pe_offset      = '0;
        pe_progress    = '0;
        mach_low       = '0;
        verdict_so_far = efs_pkg::CLS_UNKNOWN;
        foreach (hdr_copy[i]) hdr_copy[i] = '0;
    endtask

    // One byte of the PE signature or machine word, in the order it is expected.
    task automatic pe_signature_step(input logic [7:0] v);
        logic [15:0] word;
        word = {v, mach_low};
        if (pe_progress < efs_pkg::PROG_MLOW) begin
            pe_progress = (v == efs_pkg::PE_SIG[pe_progress[1:0]]) ? pe_progress + 3'd1
                                                                    : efs_pkg::PROG_OFF;
        end else if (pe_progress == efs_pkg::PROG_MLOW) begin
            mach_low    = v;
            pe_progress = efs_pkg::PROG_MHIGH;
        end else if (pe_progress == efs_pkg::PROG_MHIGH) begin
            if (word == efs_pkg::MACH_X86) begin
                verdict_so_far = efs_pkg::CLS_PE_X86;
            end else if (word == efs_pkg::MACH_X64) begin
                verdict_so_far = efs_pkg::CLS_PE_X64;
            end
            pe_progress = efs_pkg::PROG_DONE;
        end
    endtask

    // Advance the predictor by one accepted byte; the class is valid on the last byte.
    task automatic track_byte(input logic [7:0] b, input logic last,
                              output efs_pkg::t_class cls);
        longint unsigned p;
        longint unsigned at;
        p = pos_next;
        if (p < efs_pkg::HDR_BYTES) hdr_copy[p] = b;

        if (p == efs_pkg::POS_ELF_CLASS &&
            {hdr_copy[3], hdr_copy[2], hdr_copy[1], hdr_copy[0]} == efs_pkg::ELF_MAGIC) begin
            if (b == efs_pkg::ELF_CLS32) begin
                verdict_so_far = efs_pkg::CLS_ELF_32;
            end else if (b == efs_pkg::ELF_CLS64) begin
                verdict_so_far = efs_pkg::CLS_ELF_64;
            end
        end

        // At the end of the header, fetch the offset and walk any PE bytes stored there.
        if (p == efs_pkg::POS_HDR_LAST) begin
            pe_offset = {hdr_copy[efs_pkg::POS_OFF_LO+3], hdr_copy[efs_pkg::POS_OFF_LO+2],
                         hdr_copy[efs_pkg::POS_OFF_LO+1], hdr_copy[efs_pkg::POS_OFF_LO]};
            if ({hdr_copy[1], hdr_copy[0]} == efs_pkg::MZ_MAGIC) begin
                pe_progress = '0;
                at = pe_offset;
                while (pe_progress < efs_pkg::PROG_DONE &&
                       at + pe_progress < efs_pkg::HDR_BYTES)
                    pe_signature_step(hdr_copy[at + pe_progress]);
            end else begin
                pe_progress = efs_pkg::PROG_OFF;
            end
        end else if (p >= efs_pkg::HDR_BYTES && pe_progress < efs_pkg::PROG_DONE &&
                     p == longint'(pe_offset) + pe_progress) begin
            pe_signature_step(b);
        end

        if (pos_next != '1) pos_next = pos_next + 32'd1;
        cls = verdict_so_far;
        if (last) clear_tracker();
    endtask

    // Build the bytes of one file from its description.
    task automatic make_file(input t_file_case fc, output logic [7:0] img [$]);
        longint unsigned off;
        int k;
        img = {};
        off = fc.pe_off;
        for (int i = 0; i < fc.len; i++)
            img.push_back(fc.fill < 0 ? 8'($urandom) : 8'(fc.fill));
        if (fc.kind == FK_ELF) begin
            for (k = 0; k < 5 && k < fc.len; k++)
                img[k] = (k < 4) ? efs_pkg::ELF_MAGIC[8*k +: 8] : fc.elf_cls;
        end else if (fc.kind == FK_MZ) begin
            for (k = 0; k < 6; k++)
                if (off + k < fc.len)
                    img[off + k] = (k < 4) ? efs_pkg::PE_SIG[k] : fc.mach[8*(k-4) +: 8];
            if (fc.sig_bad) begin
                k = $urandom_range(3);
                if (off + k < fc.len) img[off + k] ^= 8'(1 << $urandom_range(7));
            end
            // The offset and the MZ magic win over anything placed on top of them.
            for (k = 0; k < 4; k++)
                if (efs_pkg::POS_OFF_LO + k < fc.len)
                    img[efs_pkg::POS_OFF_LO + k] = fc.pe_off[8*k +: 8];
            for (k = 0; k < 2 && k < fc.len; k++)
                img[k] = efs_pkg::MZ_MAGIC[8*k +: 8];
        end
    endtask

    // Mostly well-formed ELF and PE files with random contents, the rest noise.
    function automatic t_file_case random_case();
        t_file_case      fc;
        int              pick;
        longint unsigned reach;
        fc = '{FK_RAW, 1, -1, 8'h00, 32'h0, 16'h0, 1'b0, 1'b0, efs_pkg::CLS_UNKNOWN};
        pick = $urandom_range(99);
        if (pick < 35) begin
            fc.kind = FK_ELF;
            fc.len  = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 16);
            pick    = $urandom_range(99);
            fc.elf_cls = (pick < 45) ? efs_pkg::ELF_CLS32 :
                         (pick < 90) ? efs_pkg::ELF_CLS64 : 8'($urandom);
        end else if (pick < 75) begin
            fc.kind = FK_MZ;
            pick    = $urandom_range(99);
            if (pick < 60) begin
                fc.pe_off = $urandom_range(64, 110);
            end else if (pick < 85) begin
                fc.pe_off = $urandom_range(0, 63);
            end else if (pick < 95) begin
                fc.pe_off = $urandom_range(56, 70);
            end else begin
                fc.pe_off = $urandom;
            end
            pick    = $urandom_range(99);
            fc.mach = (pick < 45) ? efs_pkg::MACH_X86 :
                      (pick < 90) ? efs_pkg::MACH_X64 : 16'($urandom);
            fc.sig_bad = ($urandom_range(9) == 0);
            reach = longint'(fc.pe_off) + 6;
            if (reach < efs_pkg::HDR_BYTES) reach = efs_pkg::HDR_BYTES;
            if (reach > 140) reach = 70;
            if ($urandom_range(99) < 85) begin
                fc.len = int'(reach) + $urandom_range(0, 10);
            end else begin
                fc.len = $urandom_range(1, int'(reach) - 1);
            end
        end else begin
            fc.len = $urandom_range(1, 20);
        end
        return fc;
    endfunction

    // Offer one byte beat, with random idle cycles ahead of it, and predict on acceptance.
    task automatic send_beat(input logic [7:0] b, input logic last);
        efs_pkg::t_class cls;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_byte(b, last, cls);
        if (last) class_due.push_back(typed_on ? typed_cls : cls);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_file(input logic [7:0] img [$]);
        foreach (img[i]) send_beat(img[i], i == img.size() - 1);
        files_done++;
    endtask

    // Stop offering bytes until every class has arrived and the block has settled.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (class_due.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // Receiver stall: random, off during calm stretches, forced high during a hold-off.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Compare each class beat with the oldest prediction.
    always @(posedge i_clk) begin
        efs_pkg::t_class want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (class_due.size() == 0) begin
                report_mismatch("class beat with nothing due", o_file_class, 3'bx);
            end else begin
                want = class_due.pop_front();
                if (o_file_class !== want) report_mismatch("file_class", o_file_class, want);
            end
        end
    end

    // Watchdog on cycles without any beat on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence: reset, directed files with a calm stretch over the long PE files,
    // then random files with one hold-off phase early on.
    initial begin
        t_file_case fc;
        logic [7:0] img [$];
        int         n;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_data_byte  = '0;
        i_last_byte  = 1'b0;
        calm         = 1'b0;
        typed_on     = 1'b0;
        typed_cls    = efs_pkg::CLS_UNKNOWN;
        hold_left    = 0;
        beats_sent   = 0;
        files_done   = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        clear_tracker();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_cases[r]) begin
            calm      = (r >= 9 && r < 14);
            typed_on  = directed_cases[r].typed;
            typed_cls = directed_cases[r].want;
            make_file(directed_cases[r], img);
            send_file(img);
        end
        typed_on = 1'b0;
        calm     = 1'b0;

        n = 0;
        while (beats_sent < BEAT_GOAL || files_done < FILE_GOAL) begin
            // Hold the output off while short files keep coming, so the input backs up.
            if (n == 2) begin
                drain();
                hold_left = HOLD_CYCLES;
                calm      = 1'b1;
                repeat (20) begin
                    fc = '{FK_ELF, 5, -1, 8'($urandom_range(1, 2)), 32'h0, 16'h0,
                           1'b0, 1'b0, efs_pkg::CLS_UNKNOWN};
                    make_file(fc, img);
                    send_file(img);
                end
                calm = 1'b0;
                drain();
            end
            fc = random_case();
            make_file(fc, img);
            send_file(img);
            n++;
        end

        i_in_valid <= 1'b0;
        while (class_due.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
